/* design/tle_pkg.sv */
// ----------------------------------------------------------------------------
// Timed line editor package
// Shared types, codes and constants for the line editor front end, command
// queue and back end.
// ----------------------------------------------------------------------------
package tle_pkg;

   localparam int LINE_SIZE   = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] FIRST_CHAR_RESET = 16'd3;
   localparam logic [15:0] IDLE_RESET       = 16'd900;
   localparam logic [15:0] IDLE_MAX         = 16'hFFFF;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_BS    = 8'h08;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_DEL   = 8'h7F;
   localparam logic [7:0] BYTE_ESC   = 8'hFF;

   localparam logic [1:0] ESC_SKIP = 2'd2;

   localparam logic CSR_FIRST_CHAR = 1'b0;
   localparam logic CSR_IDLE       = 1'b1;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] byte_value;
      logic       short_first;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic       entered;
      logic       timed_out;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      CMD_START,
      CMD_CHAR,
      CMD_NEWLINE,
      CMD_ERASE,
      CMD_ESCAPE,
      CMD_DROP,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   byte_value;
      logic         short_first;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ECHO,
      BK_PREP,
      BK_EMIT,
      BK_END
   } back_state_type;

endpackage

/* design/tle_front.sv */
// ----------------------------------------------------------------------------
// Line editor front end
// Accepts input items and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module tle_front (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tle_pkg::req_payload_type req_payload,
   input  logic                     queue_full,
   output logic                     push,
   output tle_pkg::cmd_type         push_cmd
);

   logic known;

   always_comb begin
      known                = 1'b1;
      push_cmd.byte_value  = req_payload.byte_value;
      push_cmd.short_first = req_payload.short_first;
      push_cmd.kind        = tle_pkg::CMD_DROP;
      unique case (req_payload.opcode)
         tle_pkg::OP_START: begin
            push_cmd.kind = tle_pkg::CMD_START;
         end
         tle_pkg::OP_TICK: begin
            push_cmd.kind = tle_pkg::CMD_TICK;
         end
         tle_pkg::OP_BYTE: begin
            priority if (req_payload.byte_value == tle_pkg::BYTE_LF) begin
               push_cmd.kind = tle_pkg::CMD_NEWLINE;
            end else if (req_payload.byte_value == tle_pkg::BYTE_BS ||
                         req_payload.byte_value == tle_pkg::BYTE_DEL) begin
               push_cmd.kind = tle_pkg::CMD_ERASE;
            end else if (req_payload.byte_value == tle_pkg::BYTE_ESC) begin
               push_cmd.kind = tle_pkg::CMD_ESCAPE;
            end else if (req_payload.byte_value == tle_pkg::BYTE_CR ||
                         req_payload.byte_value == tle_pkg::BYTE_NUL) begin
               push_cmd.kind = tle_pkg::CMD_DROP;
            end else begin
               push_cmd.kind = tle_pkg::CMD_CHAR;
            end
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // Unused opcodes are taken and dropped here.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full && known;

endmodule

/* design/tle_queue.sv */
// ----------------------------------------------------------------------------
// Line editor command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tle_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tle_pkg::cmd_type        push_cmd,
   output logic                    full,
   output tle_pkg::queue_head_type head,
   input  logic                    pop
);

   localparam int PTR_W = (tle_pkg::QUEUE_DEPTH > 1) ? $clog2(tle_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(tle_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(tle_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(tle_pkg::QUEUE_DEPTH - 1);

   tle_pkg::cmd_type entry_ff [tle_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == DEPTH_CNT);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* design/tle_back.sv */
// ----------------------------------------------------------------------------
// Line editor back end
// Carries out queued commands: edits the line store, counts idle seconds,
// and produces echo, line and end results through an output register.
// ----------------------------------------------------------------------------
module tle_back #(
   parameter int LINE_SIZE = tle_pkg::LINE_SIZE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tle_pkg::queue_head_type  head,
   output logic                     pop,
   input  logic [15:0]              first_char_timeout,
   input  logic [15:0]              idle_timeout,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tle_pkg::rsp_payload_type rsp_payload
);

   localparam int CNT_W = $clog2(LINE_SIZE);
   localparam int DEPTH = LINE_SIZE - 1;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LINE_SIZE - 1);

   logic [7:0] store [DEPTH];

   tle_pkg::back_state_type  state_ff, state_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [CNT_W-1:0]         emit_idx_ff, emit_idx_in;
   logic [1:0]               skip_ff, skip_in;
   logic [1:0]               echo_cnt_ff, echo_cnt_in;
   logic [15:0]              idle_ff, idle_in;
   logic [15:0]              first_limit_ff, first_limit_in;
   logic                     reading_ff, reading_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   tle_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic [7:0]               rd_data_ff;

   logic                     out_free;
   logic                     wr_en;
   logic [CNT_W-1:0]         rd_addr;
   logic [15:0]              idle_next;
   logic [15:0]              limit;
   logic                     is_byte;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign idle_next   = (idle_ff != tle_pkg::IDLE_MAX) ? idle_ff + 16'd1 : idle_ff;
   assign limit       = (fill_ff == '0) ? first_limit_ff : idle_timeout;
   assign is_byte     = (head.cmd.kind == tle_pkg::CMD_CHAR) ||
                        (head.cmd.kind == tle_pkg::CMD_NEWLINE) ||
                        (head.cmd.kind == tle_pkg::CMD_ERASE) ||
                        (head.cmd.kind == tle_pkg::CMD_ESCAPE) ||
                        (head.cmd.kind == tle_pkg::CMD_DROP);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      emit_idx_in    = emit_idx_ff;
      skip_in        = skip_ff;
      echo_cnt_in    = echo_cnt_ff;
      idle_in        = idle_ff;
      first_limit_in = first_limit_ff;
      reading_in     = reading_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      pop            = 1'b0;
      wr_en          = 1'b0;
      rd_addr        = emit_idx_ff;
      unique case (state_ff)
         tle_pkg::BK_IDLE: begin
            if (head.valid && out_free) begin
               pop = 1'b1;
               if (head.cmd.kind == tle_pkg::CMD_START) begin
                  reading_in     = 1'b1;
                  fill_in        = '0;
                  skip_in        = '0;
                  idle_in        = '0;
                  first_limit_in = head.cmd.short_first ? first_char_timeout : idle_timeout;
               end else if (reading_ff && is_byte) begin
                  idle_in = '0;
                  if (skip_ff != '0) begin
                     skip_in = skip_ff - 2'd1;
                  end else begin
                     unique case (head.cmd.kind)
                        tle_pkg::CMD_NEWLINE: begin
                           state_in = (fill_ff == '0) ? tle_pkg::BK_END : tle_pkg::BK_PREP;
                        end
                        tle_pkg::CMD_ERASE: begin
                           if (fill_ff != '0) begin
                              fill_in     = fill_ff - 1'b1;
                              echo_cnt_in = '0;
                              state_in    = tle_pkg::BK_ECHO;
                           end
                        end
                        tle_pkg::CMD_ESCAPE: begin
                           skip_in = tle_pkg::ESC_SKIP;
                        end
                        tle_pkg::CMD_CHAR: begin
                           wr_en   = 1'b1;
                           fill_in = fill_ff + 1'b1;
                           if (fill_ff + 1'b1 == FULL_CNT) begin
                              state_in = tle_pkg::BK_PREP;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end else if (reading_ff && head.cmd.kind == tle_pkg::CMD_TICK) begin
                  idle_in = idle_next;
                  if (limit != '0 && idle_next >= limit) begin
                     reading_in                = 1'b0;
                     fill_in                   = '0;
                     skip_in                   = '0;
                     idle_in                   = '0;
                     rsp_valid_in              = 1'b1;
                     rsp_payload_in.kind       = tle_pkg::KIND_END;
                     rsp_payload_in.data       = '0;
                     rsp_payload_in.last       = 1'b1;
                     rsp_payload_in.entered    = (fill_ff == '0) &&
                                                 (first_limit_ff != idle_timeout);
                     rsp_payload_in.timed_out  = 1'b1;
                  end
               end
            end
         end
         tle_pkg::BK_ECHO: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.kind       = tle_pkg::KIND_ECHO;
               rsp_payload_in.data       = (echo_cnt_ff == 2'd1) ? tle_pkg::BYTE_SPACE
                                                                 : tle_pkg::BYTE_BS;
               rsp_payload_in.last       = (echo_cnt_ff == 2'd2);
               rsp_payload_in.entered    = 1'b0;
               rsp_payload_in.timed_out  = 1'b0;
               if (echo_cnt_ff == 2'd2) begin
                  state_in = tle_pkg::BK_IDLE;
               end else begin
                  echo_cnt_in = echo_cnt_ff + 2'd1;
               end
            end
         end
         tle_pkg::BK_PREP: begin
            rd_addr     = '0;
            emit_idx_in = '0;
            state_in    = tle_pkg::BK_EMIT;
         end
         tle_pkg::BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.kind       = tle_pkg::KIND_LINE;
               rsp_payload_in.data       = rd_data_ff;
               rsp_payload_in.last       = 1'b0;
               rsp_payload_in.entered    = 1'b0;
               rsp_payload_in.timed_out  = 1'b0;
               if (emit_idx_ff + 1'b1 == fill_ff) begin
                  state_in = tle_pkg::BK_END;
               end else begin
                  emit_idx_in = emit_idx_ff + 1'b1;
                  rd_addr     = emit_idx_ff + 1'b1;
               end
            end
         end
         tle_pkg::BK_END: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.kind       = tle_pkg::KIND_END;
               rsp_payload_in.data       = '0;
               rsp_payload_in.last       = 1'b1;
               rsp_payload_in.entered    = 1'b1;
               rsp_payload_in.timed_out  = 1'b0;
               reading_in                = 1'b0;
               fill_in                   = '0;
               skip_in                   = '0;
               idle_in                   = '0;
               state_in                  = tle_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = tle_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tle_pkg::BK_IDLE;
         fill_ff        <= '0;
         emit_idx_ff    <= '0;
         skip_ff        <= '0;
         echo_cnt_ff    <= '0;
         idle_ff        <= '0;
         first_limit_ff <= '0;
         reading_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         emit_idx_ff    <= emit_idx_in;
         skip_ff        <= skip_in;
         echo_cnt_ff    <= echo_cnt_in;
         idle_ff        <= idle_in;
         first_limit_ff <= first_limit_in;
         reading_ff     <= reading_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[fill_ff] <= head.cmd.byte_value;
      end
      rd_data_ff <= store[rd_addr];
   end

endmodule

/* design/timed_line_editor.sv */
// ----------------------------------------------------------------------------
// Timed line editor
// Line reader with simple editing and an idle timeout counted in ticks.
// ----------------------------------------------------------------------------
// Items enter on the req_ channel (start, received byte, one-second tick) and
// results leave on the rsp_ channel as echo bytes, line bytes and end items.
// Both channels move a transfer at a rising edge where valid is high and
// stall is low. The csr_ port writes the two timeout registers; the user must
// do so only while idle, as the block does not enforce it. The front end takes
// one item per cycle into a two-entry command queue and stalls only when that
// queue is full. The back end takes one command per cycle from the queue head
// while idle with its output register free. An erase on a non-empty line gives
// three echo results; a newline on a non-empty line or full line passes a
// setup state, emits each stored byte, then the end item, walking the line
// store through its registered read port. With an empty queue and no stall, a
// timeout end item goes from the queue head to the output register; an echo
// passes the echo state, a line byte the setup state and read port, an empty
// line's end item the end state. When the receiver stalls, the output register
// holds its result, the back end waits and the queue fills, after which the
// request side is stalled. Reset empties the queue, ends any read and loads
// the timeout registers with 3 and 900 seconds; the line store is not cleared.
// ----------------------------------------------------------------------------
module timed_line_editor #(
   parameter int LINE_SIZE = tle_pkg::LINE_SIZE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tle_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tle_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write,
   input  logic                     csr_index,
   input  logic [15:0]              csr_wdata
);

   logic [15:0]             first_char_ff, first_char_in;
   logic [15:0]             idle_timeout_ff, idle_timeout_in;
   logic                    queue_full;
   logic                    push;
   logic                    pop;
   tle_pkg::cmd_type        push_cmd;
   tle_pkg::queue_head_type head;

   always_comb begin
      first_char_in   = first_char_ff;
      idle_timeout_in = idle_timeout_ff;
      if (csr_write) begin
         unique case (csr_index)
            tle_pkg::CSR_FIRST_CHAR: first_char_in   = csr_wdata;
            tle_pkg::CSR_IDLE:       idle_timeout_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_char_ff   <= tle_pkg::FIRST_CHAR_RESET;
         idle_timeout_ff <= tle_pkg::IDLE_RESET;
      end else begin
         first_char_ff   <= first_char_in;
         idle_timeout_ff <= idle_timeout_in;
      end
   end

   tle_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   tle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .head     (head),
      .pop      (pop)
   );

   tle_back #(
      .LINE_SIZE (LINE_SIZE)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .first_char_timeout (first_char_ff),
      .idle_timeout       (idle_timeout_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload        (rsp_payload)
   );

endmodule
